// ===== rtl/core/clbs_pkg.sv =====
package clbs_pkg;

	typedef enum logic [2:0] {
		CMD_INIT    = 3'd0,
		CMD_INSTR   = 3'd1,
		CMD_DATA    = 3'd2,
		CMD_CURSOR  = 3'd3,
		CMD_DISPLAY = 3'd4,
		CMD_ENTRY   = 3'd5,
		CMD_GLYPH   = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		REG_BUS_EIGHT = 2'd0,
		REG_ROW_COUNT = 2'd1,
		REG_COL_COUNT = 2'd2
	} reg_idx_t;

	typedef enum logic {
		JOB_BYTE = 1'b0,
		JOB_INIT = 1'b1
	} job_kind_t;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] value;
		logic [5:0] column;
		logic [2:0] row;
		logic       flag_set;
	} in_t;

	typedef struct packed {
		logic        register_select;
		logic [7:0]  bus_value;
		logic [15:0] wait_before_us;
		logic [12:0] wait_after_us;
		logic        last;
	} out_t;

	typedef struct packed {
		logic       bus_eight_bit;
		logic [2:0] row_count;
		logic [5:0] column_count;
	} cfg_t;

	// one queued job: a byte transfer or the whole power-up sequence
	typedef struct packed {
		job_kind_t  kind;
		logic       eight;
		logic       rs;
		logic [7:0] data;
	} job_t;

	localparam logic [7:0]  INS_FUNC_SET   = 8'h20;
	localparam logic [7:0]  INS_FUNC_8BIT  = 8'h10;
	localparam logic [7:0]  INS_FUNC_2LINE = 8'h08;
	localparam logic [7:0]  INS_DISPLAY    = 8'h08;
	localparam logic [7:0]  INS_ENTRY      = 8'h04;
	localparam logic [7:0]  INS_CLEAR      = 8'h01;
	localparam logic [7:0]  INS_HOME       = 8'h02;
	localparam logic [7:0]  INS_CGRAM      = 8'h40;
	localparam logic [7:0]  INS_DDRAM      = 8'h80;
	localparam logic [7:0]  WAKE_BYTE      = 8'h30;
	localparam logic [7:0]  WAKE_NIB       = 8'h03;
	localparam logic [7:0]  WAKE_NIB_4BIT  = 8'h02;

	localparam logic [2:0]  DISPLAY_RESET  = 3'b100;
	localparam logic [1:0]  ENTRY_RESET    = 2'b10;

	localparam logic [15:0] WAIT_POWER_US  = 16'd50000;
	localparam logic [12:0] WAIT_BASE_US   = 13'd50;
	localparam logic [12:0] WAIT_SLOW_US   = 13'd2050;
	localparam logic [12:0] WAIT_WAKE0_US  = 13'd5050;
	localparam logic [12:0] WAIT_WAKE_US   = 13'd200;

	localparam logic [3:0]  LAST_INIT_8    = 4'd7;
	localparam logic [3:0]  LAST_INIT_4    = 4'd13;
	localparam logic [3:0]  WAKE_STEPS_8   = 4'd3;
	localparam logic [3:0]  WAKE_STEPS_4   = 4'd4;

	function automatic logic [7:0] row_base(input logic [1:0] r);
		logic [7:0] b;
		unique case (r)
			2'd0: b = 8'h00;
			2'd1: b = 8'h40;
			2'd2: b = 8'h14;
			2'd3: b = 8'h54;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] init_byte(input logic [2:0] k, input logic [7:0] fs);
		logic [7:0] b;
		unique case (k)
			3'd0: b = fs;
			3'd1: b = INS_DISPLAY;
			3'd2: b = INS_CLEAR;
			3'd3: b = INS_ENTRY | {6'd0, ENTRY_RESET};
			3'd4: b = INS_DISPLAY | {5'd0, DISPLAY_RESET};
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic out_t make_xfer(input job_t j, input logic [3:0] step);
		out_t       o;
		logic [7:0] b;
		logic [3:0] rel;
		logic       hi;
		logic       wake;
		logic       extra;
		o     = '0;
		b     = j.data;
		hi    = 1'b0;
		wake  = 1'b0;
		rel   = 4'd0;
		if (j.kind == JOB_INIT) begin
			if (j.eight) begin
				wake = (step < WAKE_STEPS_8);
				rel  = step - WAKE_STEPS_8;
				b    = init_byte(rel[2:0], j.data);
			end else begin
				wake = (step < WAKE_STEPS_4);
				rel  = step - WAKE_STEPS_4;
				b    = init_byte(rel[3:1], j.data);
				hi   = ~rel[0];
			end
			o.last = (step == (j.eight ? LAST_INIT_8 : LAST_INIT_4));
		end else begin
			hi     = ~j.eight && (step == 4'd0);
			o.last = j.eight || (step != 4'd0);
		end
		extra = ~j.rs && ((b == INS_CLEAR) || (b == INS_HOME));
		if (wake) begin
			o.register_select = 1'b0;
			if (j.eight)
				o.bus_value = WAKE_BYTE;
			else if (step == WAKE_STEPS_4 - 4'd1)
				o.bus_value = WAKE_NIB_4BIT;
			else
				o.bus_value = WAKE_NIB;
			o.wait_before_us = (step == 4'd0) ? WAIT_POWER_US : 16'd0;
			o.wait_after_us  = (step == 4'd0) ? WAIT_WAKE0_US : WAIT_WAKE_US;
		end else begin
			o.register_select = j.rs;
			if (j.eight)
				o.bus_value = b;
			else if (hi)
				o.bus_value = {4'd0, b[7:4]};
			else
				o.bus_value = {4'd0, b[3:0]};
			o.wait_before_us = 16'd0;
			o.wait_after_us  = (!hi && extra) ? WAIT_SLOW_US : WAIT_BASE_US;
		end
		return o;
	endfunction

endpackage

// ===== rtl/core/char_lcd_bus_sequencer_unit.sv =====
// channel | direction | handshake            | payload
// in      | request   | in_valid / in_ready   | in_data   (command, value, column, row, flag_set)
// out     | transfer  | out_valid / out_ready | out_data  (register_select, bus_value, waits, last)
// cfg     | write/read| psel/penable/pwrite   | paddr, pwdata, prdata
// One transfer leaves per cycle unless out stalls: a byte request gives 1 transfer (8-bit) or 2
// (4-bit), init 8 (8-bit) or 14 (4-bit); the back sequencer stepping one per cycle sets this.
// A request is accepted while the two-entry job queue has room, also while out is stalled.
// Reset sets config to 4-bit, 2 rows, 16 columns, and the display and entry flags to power-up.
module char_lcd_bus_sequencer_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  clbs_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output clbs_pkg::out_t out_data,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [3:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import clbs_pkg::*;

	cfg_t     cfg_q;
	logic     push_valid;
	job_t     push_job;
	job_t     pop_job;
	logic     fifo_full;
	logic     pop_valid;
	logic     pop;
	logic     wr_en;
	reg_idx_t reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bus_eight_bit <= 1'b0;
			cfg_q.row_count     <= 3'd2;
			cfg_q.column_count  <= 6'd16;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_BUS_EIGHT: cfg_q.bus_eight_bit <= pwdata[0];
				REG_ROW_COUNT: cfg_q.row_count     <= pwdata[2:0];
				REG_COL_COUNT: cfg_q.column_count  <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_BUS_EIGHT: prdata = {31'd0, cfg_q.bus_eight_bit};
			REG_ROW_COUNT: prdata = {29'd0, cfg_q.row_count};
			REG_COL_COUNT: prdata = {26'd0, cfg_q.column_count};
			default: prdata = 32'd0;
		endcase
	end

	clbs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (~fifo_full),
		.push_job   (push_job)
	);

	clbs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.push_job  (push_job),
		.full      (fifo_full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_job   (pop_job)
	);

	clbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job       (pop_job),
		.job_pop   (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/core/clbs_front.sv =====
module clbs_front (
	input  logic            clk,
	input  logic            arst_n,
	input  clbs_pkg::cfg_t  cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  clbs_pkg::in_t   in_data,
	output logic            push_valid,
	input  logic            push_ready,
	output clbs_pkg::job_t  push_job
);
	import clbs_pkg::*;

	logic [2:0] display_q;
	logic [1:0] entry_q;
	logic [2:0] display_nx;
	logic [1:0] entry_nx;
	logic       accept;
	logic       known;
	logic [2:0] rows;
	logic [5:0] cols;
	logic [2:0] row_c;
	logic [1:0] row_l;
	logic [5:0] col_c;
	logic [7:0] addr;
	logic [7:0] fs;

	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		rows  = (cfg.row_count == 3'd0) ? 3'd1 : cfg.row_count;
		cols  = (cfg.column_count == 6'd0) ? 6'd1 : cfg.column_count;
		row_c = (in_data.row >= rows) ? rows - 3'd1 : in_data.row;
		row_l = (row_c > 3'd3) ? 2'd3 : row_c[1:0];
		col_c = (in_data.column >= cols) ? cols - 6'd1 : in_data.column;
		addr  = INS_DDRAM | ({2'd0, col_c} + row_base(row_l));
		fs    = INS_FUNC_SET | (cfg.bus_eight_bit ? INS_FUNC_8BIT : 8'h00)
			| ((rows > 3'd1) ? INS_FUNC_2LINE : 8'h00);
		display_nx = in_data.flag_set ? (display_q | in_data.value[2:0])
			: (display_q & ~in_data.value[2:0]);
		entry_nx   = in_data.flag_set ? (entry_q | in_data.value[1:0])
			: (entry_q & ~in_data.value[1:0]);
	end

	always_comb begin
		push_job       = '0;
		push_job.kind  = JOB_BYTE;
		push_job.eight = cfg.bus_eight_bit;
		known          = 1'b1;
		unique case (cmd_t'(in_data.command))
			CMD_INIT: begin
				push_job.kind = JOB_INIT;
				push_job.data = fs;
			end
			CMD_INSTR: push_job.data = in_data.value;
			CMD_DATA: begin
				push_job.rs   = 1'b1;
				push_job.data = in_data.value;
			end
			CMD_CURSOR: push_job.data = addr;
			CMD_DISPLAY: push_job.data = INS_DISPLAY | {5'd0, display_nx};
			CMD_ENTRY: push_job.data = INS_ENTRY | {6'd0, entry_nx};
			CMD_GLYPH: push_job.data = INS_CGRAM | {2'd0, in_data.value[2:0], 3'd0};
			default: known = 1'b0;
		endcase
	end

	assign push_valid = accept && known;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_q <= DISPLAY_RESET;
			entry_q   <= ENTRY_RESET;
		end else if (accept) begin
			if (in_data.command == CMD_INIT) begin
				display_q <= DISPLAY_RESET;
				entry_q   <= ENTRY_RESET;
			end else if (in_data.command == CMD_DISPLAY) begin
				display_q <= display_nx;
			end else if (in_data.command == CMD_ENTRY) begin
				entry_q <= entry_nx;
			end
		end
	end

endmodule

// ===== rtl/core/clbs_fifo.sv =====
module clbs_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  clbs_pkg::job_t  push_job,
	output logic            full,
	input  logic            pop,
	output logic            pop_valid,
	output clbs_pkg::job_t  pop_job
);
	import clbs_pkg::*;

	job_t       entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_job   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

// ===== rtl/core/clbs_back.sv =====
module clbs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	input  clbs_pkg::job_t  job,
	output logic            job_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output clbs_pkg::out_t  out_data
);
	import clbs_pkg::*;

	job_t       cur_q;
	logic       cur_valid_q;
	logic [3:0] step_q;
	out_t       out_q;
	logic       out_valid_q;
	out_t       xfer;
	logic       advance;
	logic       done;

	assign xfer    = make_xfer(cur_q, step_q);
	assign advance = cur_valid_q && (!out_valid_q || out_ready);
	assign done    = advance && xfer.last;
	assign job_pop = job_valid && (!cur_valid_q || done);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (job_pop)
			cur_q <= job;
		if (advance)
			out_q <= xfer;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			step_q      <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (job_pop) begin
				cur_valid_q <= 1'b1;
				step_q      <= 4'd0;
			end else if (done) begin
				cur_valid_q <= 1'b0;
				step_q      <= 4'd0;
			end else if (advance) begin
				step_q <= step_q + 4'd1;
			end
		end
	end

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> step_q <= LAST_INIT_4)
		else $error("step past end of sequence");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done && !job_valid |=> !cur_valid_q)
		else $error("job kept after last transfer");

	a_fresh_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> cur_valid_q && step_q == 4'd0)
		else $error("new job not started at step zero");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("transfer lost");

endmodule

// ===== dv/char_lcd_bus_sequencer_unit_test.sv =====
module char_lcd_bus_sequencer_unit_test;
	import clbs_pkg::*;

	localparam logic [2:0]  CMD_UNKNOWN  = 3'd7;
	localparam logic [7:0]  INS_CLR      = 8'h01;
	localparam logic [7:0]  INS_HOM      = 8'h02;
	localparam logic [15:0] POWER_WAIT   = 16'd50000;
	localparam logic [12:0] STROBE_WAIT  = 13'd50;
	localparam logic [12:0] SLOW_EXTRA   = 13'd2000;
	localparam logic [12:0] WAKE_FIRST   = 13'd5050;
	localparam logic [12:0] WAKE_NEXT    = 13'd200;
	localparam int          IDLE_LIMIT   = 3000;
	localparam int          SETTLE       = 40;
	localparam int          PHASE_ITEMS  = 38;

	class transfer_predictor;
		logic       eight;
		logic [2:0] rows;
		logic [5:0] cols;
		logic [2:0] disp;
		logic [1:0] entry;
		out_t       pending[$];
		int         errors;

		function new();
			eight  = 1'b0;
			rows   = 3'd2;
			cols   = 6'd16;
			disp   = 3'b100;
			entry  = 2'b10;
			errors = 0;
		endfunction

		function void set_config(reg_idx_t idx, logic [31:0] v);
			case (idx)
				REG_BUS_EIGHT: eight = v[0];
				REG_ROW_COUNT: rows  = v[2:0];
				REG_COL_COUNT: cols  = v[5:0];
				default: ;
			endcase
		endfunction

		function void add(logic rs, logic [7:0] bus, logic [15:0] pre, logic [12:0] post);
			out_t t;
			t.register_select = rs;
			t.bus_value       = bus;
			t.wait_before_us  = pre;
			t.wait_after_us   = post;
			t.last            = 1'b0;
			pending.push_back(t);
		endfunction

		function void send_byte(logic rs, logic [7:0] b, logic [12:0] extra);
			if (eight) begin
				add(rs, b, 16'd0, STROBE_WAIT + extra);
			end else begin
				add(rs, {4'd0, b[7:4]}, 16'd0, STROBE_WAIT);
				add(rs, {4'd0, b[3:0]}, 16'd0, STROBE_WAIT + extra);
			end
		endfunction

		function void send_instr(logic [7:0] b);
			send_byte(1'b0, b, (b == INS_CLR || b == INS_HOM) ? SLOW_EXTRA : 13'd0);
		endfunction

		function void note_request(in_t r);
			int         n0;
			logic [2:0] eff_rows;
			logic [5:0] eff_cols;
			logic [2:0] row;
			logic [5:0] col;
			logic [7:0] fs;
			logic [7:0] base;
			out_t       t;
			n0       = pending.size();
			eff_rows = (rows == 0) ? 3'd1 : rows;
			eff_cols = (cols == 0) ? 6'd1 : cols;
			case (r.command)
				CMD_INIT: begin
					disp  = 3'b100;
					entry = 2'b10;
					if (eight) begin
						add(1'b0, 8'h30, POWER_WAIT, WAKE_FIRST);
						add(1'b0, 8'h30, 16'd0, WAKE_NEXT);
						add(1'b0, 8'h30, 16'd0, WAKE_NEXT);
						fs = 8'h30;
					end else begin
						add(1'b0, 8'h03, POWER_WAIT, WAKE_FIRST);
						add(1'b0, 8'h03, 16'd0, WAKE_NEXT);
						add(1'b0, 8'h03, 16'd0, WAKE_NEXT);
						add(1'b0, 8'h02, 16'd0, WAKE_NEXT);
						fs = 8'h20;
					end
					if (eff_rows > 1)
						fs = fs | 8'h08;
					send_instr(fs);
					send_instr(8'h08);
					send_instr(INS_CLR);
					send_instr(8'h04 | {6'd0, entry});
					send_instr(8'h08 | {5'd0, disp});
				end
				CMD_INSTR: send_instr(r.value);
				CMD_DATA: send_byte(1'b1, r.value, 13'd0);
				CMD_CURSOR: begin
					row = r.row;
					col = r.column;
					if (row >= eff_rows)
						row = eff_rows - 3'd1;
					if (row > 3)
						row = 3'd3;
					if (col >= eff_cols)
						col = eff_cols - 6'd1;
					case (row[1:0])
						2'd0: base = 8'h00;
						2'd1: base = 8'h40;
						2'd2: base = 8'h14;
						default: base = 8'h54;
					endcase
					send_instr(8'h80 | ({2'd0, col} + base));
				end
				CMD_DISPLAY: begin
					if (r.flag_set)
						disp = disp | r.value[2:0];
					else
						disp = disp & ~r.value[2:0];
					send_instr(8'h08 | {5'd0, disp});
				end
				CMD_ENTRY: begin
					if (r.flag_set)
						entry = entry | r.value[1:0];
					else
						entry = entry & ~r.value[1:0];
					send_instr(8'h04 | {6'd0, entry});
				end
				CMD_GLYPH: send_instr(8'h40 | {2'd0, r.value[2:0], 3'd0});
				default: ;
			endcase
			if (pending.size() > n0) begin
				t = pending[pending.size() - 1];
				t.last = 1'b1;
				pending[pending.size() - 1] = t;
			end
		endfunction

		function void check_transfer(out_t got);
			out_t exp;
			if (pending.size() == 0) begin
				$error("transfer with no request outstanding: %h", got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.register_select !== exp.register_select) begin
				$error("register_select: expected %0d, got %0d",
					exp.register_select, got.register_select);
				errors++;
			end
			if (got.bus_value !== exp.bus_value) begin
				$error("bus_value: expected %h, got %h", exp.bus_value, got.bus_value);
				errors++;
			end
			if (got.wait_before_us !== exp.wait_before_us) begin
				$error("wait_before_us: expected %0d, got %0d",
					exp.wait_before_us, got.wait_before_us);
				errors++;
			end
			if (got.wait_after_us !== exp.wait_after_us) begin
				$error("wait_after_us: expected %0d, got %0d",
					exp.wait_after_us, got.wait_after_us);
				errors++;
			end
			if (got.last !== exp.last) begin
				$error("last: expected %0d, got %0d", exp.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_t         in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_t        out_data;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [3:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;

	transfer_predictor sb;
	int burst_left  = 0;
	int idle_cycles = 0;
	int stall_mode  = 0;
	int stall_left  = 0;

	char_lcd_bus_sequencer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_transfer(out_data);
			if (in_valid && in_ready)
				sb.note_request(in_data);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// receiver stall pattern: runs of full speed, light, heavy and random back-pressure
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 7) != 0);
			2: out_ready <= ($urandom_range(0, 4) == 0);
			default: out_ready <= 1'($urandom_range(0, 1));
		endcase
	end

	task automatic offer(in_t r);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 10);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic request(logic [2:0] cmd, logic [7:0] v, logic [5:0] col, logic [2:0] row,
			logic fset);
		in_t r;
		r.command  = cmd;
		r.value    = v;
		r.column   = col;
		r.row      = row;
		r.flag_set = fset;
		offer(r);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.set_config(idx, v);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	function automatic in_t random_request();
		in_t r;
		int  pick;
		pick       = $urandom_range(0, 99);
		r.value    = 8'($urandom_range(0, 255));
		r.column   = ($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, 63))
			: 6'($urandom_range(0, 15));
		r.row      = 3'($urandom_range(0, 7));
		r.flag_set = 1'($urandom_range(0, 1));
		if (pick < 8)
			r.command = CMD_INIT;
		else if (pick < 24)
			r.command = CMD_INSTR;
		else if (pick < 48)
			r.command = CMD_DATA;
		else if (pick < 68)
			r.command = CMD_CURSOR;
		else if (pick < 79)
			r.command = CMD_DISPLAY;
		else if (pick < 90)
			r.command = CMD_ENTRY;
		else if (pick < 97)
			r.command = CMD_GLYPH;
		else
			r.command = CMD_UNKNOWN;
		if (r.command == CMD_INSTR && $urandom_range(0, 3) == 0)
			r.value = ($urandom_range(0, 1) != 0) ? INS_CLR : INS_HOM;
		return r;
	endfunction

	initial begin
		logic [31:0] setting[8][3];
		in_t         r;
		int          useful;
		setting = '{
			'{32'd1, 32'd4, 32'd40},
			'{32'd0, 32'd1, 32'd1},
			'{32'd1, 32'd0, 32'd0},
			'{32'd0, 32'd7, 32'd63},
			'{32'd1, 32'd2, 32'd16},
			'{32'd0, 32'd4, 32'd40},
			'{32'd1, 32'd7, 32'd63},
			'{32'd0, 32'd3, 32'd20}
		};
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		request(CMD_INIT,    8'h00, 6'd0,  3'd0, 1'b0);
		request(CMD_INSTR,   INS_CLR, 6'd0, 3'd0, 1'b0);
		request(CMD_INSTR,   INS_HOM, 6'd0, 3'd0, 1'b0);
		request(CMD_INSTR,   8'h00, 6'd0,  3'd0, 1'b0);
		request(CMD_INSTR,   8'hff, 6'd63, 3'd7, 1'b1);
		request(CMD_DATA,    8'h00, 6'd0,  3'd0, 1'b0);
		request(CMD_DATA,    8'hff, 6'd0,  3'd0, 1'b0);
		request(CMD_CURSOR,  8'h00, 6'd63, 3'd7, 1'b0);
		request(CMD_CURSOR,  8'h00, 6'd0,  3'd0, 1'b0);
		request(CMD_CURSOR,  8'h00, 6'd15, 3'd1, 1'b0);
		request(CMD_DISPLAY, 8'hff, 6'd0,  3'd0, 1'b1);
		request(CMD_DISPLAY, 8'h05, 6'd0,  3'd0, 1'b0);
		request(CMD_DISPLAY, 8'hfa, 6'd0,  3'd0, 1'b1);
		request(CMD_ENTRY,   8'hff, 6'd0,  3'd0, 1'b1);
		request(CMD_ENTRY,   8'h01, 6'd0,  3'd0, 1'b0);
		request(CMD_ENTRY,   8'hfc, 6'd0,  3'd0, 1'b1);
		request(CMD_GLYPH,   8'hff, 6'd0,  3'd0, 1'b0);
		request(CMD_GLYPH,   8'h00, 6'd0,  3'd0, 1'b0);
		request(CMD_UNKNOWN, 8'hff, 6'd63, 3'd7, 1'b1);
		request(CMD_INIT,    8'hff, 6'd63, 3'd7, 1'b1);

		for (int p = 0; p < 8; p++) begin
			drain();
			write_reg(REG_BUS_EIGHT, setting[p][0]);
			write_reg(REG_ROW_COUNT, setting[p][1]);
			write_reg(REG_COL_COUNT, setting[p][2]);
			@(posedge clk);
			request(CMD_INIT, 8'($urandom_range(0, 255)), 6'd0, 3'd0, 1'b0);
			useful = 1;
			while (useful < PHASE_ITEMS) begin
				r = random_request();
				if (r.command != CMD_UNKNOWN)
					useful++;
				offer(r);
			end
		end

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$error("no request or transfer accepted for %0d cycles", IDLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== char_lcd_bus_sequencer_unit.f =====
rtl/core/clbs_pkg.sv
rtl/core/clbs_front.sv
rtl/core/clbs_fifo.sv
rtl/core/clbs_back.sv
rtl/core/char_lcd_bus_sequencer_unit.sv
dv/char_lcd_bus_sequencer_unit_test.sv
